/* hw/rtl/swma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_pkg
// Shared widths, reset values and controller/datapath interface types for the
// sliding-window moving average.
// ----------------------------------------------------------------------------
package swma_pkg;

  // Fixed field widths
  localparam int SMP_W  = 32;  // input sample
  localparam int AVG_W  = 48;  // fixed-point average
  localparam int HELD_W = 7;   // samples held
  localparam int WIN_W  = 7;   // window size register

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic cap;     // capture input word
    logic rd;      // read oldest ring slot
    logic upd;     // update ring, sum, pointers
    logic dstart;  // load divider
    logic oload;   // load output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_done;  // last divide step this cycle
  } stat_t;

endpackage

/* hw/rtl/swma_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swma_div #(
  parameter int DVD_W = 54,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step: shift in next dividend bit, trial subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign done  = busy_r && (cnt_r == CNT_W'(1));

  // Step control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (done) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Quotient / remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient = quo_r;

endmodule

/* hw/rtl/swma_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_dp
// Datapath: sample ring, running sum, fill/slot pointers, divider and output
// register.
// ----------------------------------------------------------------------------
module swma_dp import swma_pkg::*; #(
  parameter int WINDOW_MAX    = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [WIN_W-1:0]        cfg_wdata,
  input  logic signed [SMP_W-1:0] in_sample,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic signed [AVG_W-1:0] out_average,
  output logic [HELD_W-1:0]       out_samples_held
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SMP_W + SLOT_W;
  localparam int DIV_W  = SUM_W + FRACTION_BITS;
  localparam int QW     = (DIV_W > AVG_W) ? DIV_W : AVG_W;
  localparam int CW     = (CNT_W > WIN_W) ? CNT_W + 1 : WIN_W + 1;

  logic [WIN_W-1:0]        win_r;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SMP_W-1:0] smp_r;
  logic signed [SMP_W-1:0] old_r;
  logic                    neg_r;
  logic signed [AVG_W-1:0] avg_r;
  logic [HELD_W-1:0]       held_r;

  logic [SMP_W-1:0]        ring [WINDOW_MAX];

  logic [CNT_W-1:0]        win_eff;
  logic [SLOT_W-1:0]       cur_slot;
  logic [CNT_W-1:0]        slot_inc;
  logic                    full;
  logic [SUM_W-1:0]        mag;
  logic [DIV_W-1:0]        dividend;
  logic [DIV_W-1:0]        quo;
  logic [QW-1:0]           q_ext;
  logic [QW-1:0]           res;

  // Effective window: zero acts as one, clamp at WINDOW_MAX
  always_comb begin
    if (win_r == '0)
      win_eff = CNT_W'(1);
    else if (CW'(win_r) > CW'(WINDOW_MAX))
      win_eff = CNT_W'(WINDOW_MAX);
    else
      win_eff = CNT_W'(win_r);
  end

  // Current slot and pointer/sum update
  assign cur_slot = (CNT_W'(slot_r) >= win_eff) ? '0 : slot_r;
  assign slot_inc = CNT_W'(cur_slot) + CNT_W'(1);
  assign full     = (fill_r >= win_eff);

  always_comb begin
    slot_nxt = (slot_inc >= win_eff) ? '0 : SLOT_W'(slot_inc);
    fill_nxt = full ? win_eff : fill_r + CNT_W'(1);
    sum_nxt  = sum_r + SUM_W'(smp_r) - (full ? SUM_W'(old_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cfg_we) begin
      win_r  <= cfg_wdata;
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cmd.upd) begin
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.cap) smp_r <= in_sample;
  end

  // Sample ring: read oldest, then overwrite with new
  always_ff @(posedge clk) begin
    if (cmd.rd)  old_r <= ring[cur_slot];
    if (cmd.upd) ring[cur_slot] <= smp_r;
  end

  // Divider operands: |sum| scaled by 2^FRACTION_BITS
  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dividend = DIV_W'(mag) << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (cmd.dstart) neg_r <= sum_r[SUM_W-1];
  end

  swma_div #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.dstart),
    .dividend (dividend),
    .divisor  (fill_r),
    .quotient (quo),
    .done     (stat.div_done)
  );

  // Sign restore and output register
  assign q_ext = QW'(quo);
  assign res   = neg_r ? (~q_ext + QW'(1)) : q_ext;

  always_ff @(posedge clk) begin
    if (cmd.oload) begin
      avg_r  <= res[AVG_W-1:0];
      held_r <= HELD_W'(fill_r);
    end
  end

  assign out_average      = avg_r;
  assign out_samples_held = held_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_MAX))
    else $error("fill count above window maximum");

  a_upd_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && !cfg_we |=> fill_r != '0)
    else $error("fill count zero after update");

endmodule

/* hw/rtl/swma_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_ctrl
// Controller: sequences read, update, divide and output load for each word.
// ----------------------------------------------------------------------------
module swma_ctrl import swma_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DST  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DST;
      end
      S_DST: begin
        cmd.dstart = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.oload = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.oload)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_accept_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_RD)
    else $error("accepted word did not start ring read");

  a_oload_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.oload |-> !out_valid_r || out_ready)
    else $error("output register overwritten before taken");

  a_done_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

endmodule

/* hw/rtl/sliding_window_moving_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_moving_average
// Moving average of the last window_size signed samples, 16-bit fraction.
// ----------------------------------------------------------------------------
// Each accepted sample produces one average word. Between acceptance and the
// next acceptance a word passes through a ring read, a sum update, a divider
// load, DIV_W restoring divide steps at one quotient bit per cycle (DIV_W is
// the divider width, 32 + log2(WINDOW_MAX) + FRACTION_BITS = 54 at defaults),
// and an output load that waits until the previous average is taken. A new
// sample may be accepted while the previous average still waits on out_ready.
// Writing cfg_wdata through cfg_we empties the window; a size of zero acts as
// one and sizes above WINDOW_MAX act as WINDOW_MAX.
// ----------------------------------------------------------------------------
module sliding_window_moving_average import swma_pkg::*; #(
  parameter int WINDOW_MAX    = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [WIN_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [AVG_W-1:0] out_average,
  output logic [HELD_W-1:0]       out_samples_held
);

  cmd_t  cmd;
  stat_t stat;

  swma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  swma_dp #(
    .WINDOW_MAX    (WINDOW_MAX),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .stat             (stat),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

endmodule
